// File: rtl/pdu_pkg.sv
// Shared types and constants for the packed date unpacker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package pdu_pkg;

    // Stream layout
    localparam int DATE_BITS     = 15;
    localparam int PART_BITS     = DATE_BITS - 1;
    localparam int CNT_BITS      = 4;
    localparam int MAX_OUT       = 3;
    localparam int WORD_BITS_DEF = 32;

    // Configuration
    localparam int               BASE_BITS       = 12;
    localparam int               YEAR_BITS       = 13;
    localparam logic [BASE_BITS-1:0] YEAR_BASE_RESET = 12'd1970;

    // Queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // Day sits in the low bits of a date, the year offset in the high bits
    typedef struct packed {
        logic [5:0] offset;
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    // One word's worth of dates, count is 1..MAX_OUT
    typedef struct packed {
        logic [1:0]              count;
        t_date [MAX_OUT-1:0]     dates;
    } t_job;

endpackage

`default_nettype wire

// File: rtl/packed_date_unpacker_with_parity.sv
// Top level of the packed date unpacker: front end, job queue, back end and
// the year base register. Depends on pdu_pkg, pdu_front, pdu_queue, pdu_back.
//
//  channel  handshake                  payload
//  -------  -------------------------  ------------------------------------------
//  input    i_in_valid / o_in_ready    i_data_word, i_parity_flag, i_end_of_stream
//  output   o_out_valid / i_out_ready  o_day, o_month, o_year, o_last_of_run
//  config   i_cfg_valid / o_cfg_ready  i_cfg_year_base
//
// A word is split and checked in the cycle it is accepted; its dates pass
// through the job queue into the output register, one per cycle while the
// output is taken. A word yields n dates (0..3), each held in the output until
// taken, so the output port sets the sustained rate. Words take the input every
// cycle while the two-entry queue has room. Reset is synchronous and clears
// state and queue; the config port is always ready.
`default_nettype none

module packed_date_unpacker_with_parity #(
    parameter int WORD_BITS = pdu_pkg::WORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [WORD_BITS-1:0]          i_data_word,
    input  wire logic                          i_parity_flag,
    input  wire logic                          i_end_of_stream,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [4:0]                         o_day,
    output logic [3:0]                         o_month,
    output logic [pdu_pkg::YEAR_BITS-1:0]      o_year,
    output logic                               o_last_of_run,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pdu_pkg::BASE_BITS-1:0] i_cfg_year_base
);
    import pdu_pkg::*;

    logic [BASE_BITS-1:0] r_year_base;
    logic                 accept;
    logic                 push;
    t_job                 push_job;
    logic                 pop;
    logic                 full;
    logic                 empty;
    t_job                 head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !full;
    assign accept      = i_in_valid && o_in_ready;

    // Year base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_base <= YEAR_BASE_RESET;
        end else if (i_cfg_valid) begin
            r_year_base <= i_cfg_year_base;
        end
    end

    pdu_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_data_word),
        .i_parity (i_parity_flag),
        .i_eos    (i_end_of_stream),
        .o_push   (push),
        .o_job    (push_job)
    );

    pdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    pdu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!empty),
        .i_head       (head),
        .i_year_base  (r_year_base),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_day        (o_day),
        .o_month      (o_month),
        .o_year       (o_year),
        .o_last       (o_last_of_run)
    );

endmodule

`default_nettype wire

// File: rtl/pdu_front.sv
// Front end: checks parity, splits each word into 15-bit dates, tracks the
// partial date and skip run across words. Depends on pdu_pkg.
`default_nettype none

module pdu_front #(
    parameter int WORD_BITS = pdu_pkg::WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic                 i_parity,
    input  wire logic                 i_eos,
    output logic                      o_push,
    output pdu_pkg::t_job             o_job
);
    import pdu_pkg::*;

    localparam int MAX_FULL = WORD_BITS / DATE_BITS;
    localparam int NCAND    = MAX_FULL + 1;
    localparam int EXT_W    = WORD_BITS + DATE_BITS;
    localparam int CW       = $clog2(WORD_BITS + DATE_BITS + 1);
    localparam int NF_W     = $clog2(MAX_FULL + 1);

    logic [PART_BITS-1:0] r_pbits, n_pbits;
    logic [CNT_BITS-1:0]  r_pcount, n_pcount;
    logic [CNT_BITS-1:0]  r_skip, n_skip;

    logic                 good;
    logic [CNT_BITS-1:0]  pos;
    logic [CW-1:0]        pos_ext;
    logic [EXT_W-1:0]     shifted;
    logic [NF_W-1:0]      nfull;
    logic [PART_BITS-1:0] tail;
    logic [CW-1:0]        tail_cnt;
    logic [CW-1:0]        rem;
    logic [28:0]          pmix;
    t_date                cand [NCAND];
    logic                 cand_ok [NCAND];
    t_job                 job;
    logic [1:0]           cnt;

    // Parity check and start of the first whole date in this word
    always_comb begin
        good = ((^i_word) == i_parity);
        if (r_skip != '0) begin
            pos = r_skip;
        end else if (r_pcount != '0) begin
            pos = CNT_BITS'(DATE_BITS) - r_pcount;
        end else begin
            pos = '0;
        end
        pos_ext = CW'(pos);
        shifted = {{DATE_BITS{1'b0}}, i_word} >> pos;
    end

    // Count whole dates and pick up the tail that runs into the next word
    always_comb begin
        nfull = '0;
        for (int k = 1; k <= MAX_FULL; k++) begin
            if (pos_ext + CW'(DATE_BITS * k) <= CW'(WORD_BITS)) begin
                nfull = NF_W'(k);
            end
        end
        tail     = '0;
        tail_cnt = '0;
        for (int k = 0; k <= MAX_FULL; k++) begin
            if (nfull == NF_W'(k)) begin
                tail     = shifted[DATE_BITS*k +: PART_BITS];
                tail_cnt = CW'(WORD_BITS - DATE_BITS * k) - pos_ext;
            end
        end
    end

    // Bits of a broken date left over past the word's end
    always_comb begin
        rem = CW'(WORD_BITS) - pos_ext;
        for (int k = 0; k < MAX_FULL; k++) begin
            if (rem >= CW'(DATE_BITS)) begin
                rem = rem - CW'(DATE_BITS);
            end
        end
    end

    // Gather candidates in stream order and keep the first valid ones
    always_comb begin
        pmix    = 29'(r_pbits) | (29'(i_word[DATE_BITS-1:0]) << r_pcount);
        cand[0] = pmix[DATE_BITS-1:0];
        cand_ok[0] = good && (r_pcount != '0) && (r_skip == '0);
        for (int k = 0; k < MAX_FULL; k++) begin
            cand[k+1]    = shifted[DATE_BITS*k +: DATE_BITS];
            cand_ok[k+1] = good && (NF_W'(k) < nfull);
        end
        job = '0;
        cnt = '0;
        for (int k = 0; k < NCAND; k++) begin
            if (cand_ok[k] && (cand[k].day != '0) && (cand[k].month != '0)
                    && (cnt < 2'(MAX_OUT))) begin
                job.dates[cnt] = cand[k];
                cnt = cnt + 2'd1;
            end
        end
        job.count = cnt;
    end

    // Next stream state
    always_comb begin
        if (good) begin
            n_pcount = CNT_BITS'(tail_cnt);
            n_pbits  = tail;
            n_skip   = '0;
        end else begin
            n_pcount = '0;
            n_pbits  = '0;
            n_skip   = (rem != '0) ? CNT_BITS'(CW'(DATE_BITS) - rem) : '0;
        end
        if (i_eos) begin
            n_pcount = '0;
            n_pbits  = '0;
            n_skip   = '0;
        end
    end

    // Advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits  <= '0;
            r_pcount <= '0;
            r_skip   <= '0;
        end else if (i_accept) begin
            r_pbits  <= n_pbits;
            r_pcount <= n_pcount;
            r_skip   <= n_skip;
        end
    end

    assign o_push = i_accept && (cnt != '0);
    assign o_job  = job;

endmodule

`default_nettype wire

// File: rtl/pdu_queue.sv
// Short queue of per-word date jobs between front and back end.
// Depends on pdu_pkg.
`default_nettype none

module pdu_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pdu_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output pdu_pkg::t_job      o_head
);
    import pdu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/pdu_back.sv
// Back end: walks the dates of the head job into the output register,
// adding the year base. Depends on pdu_pkg.
`default_nettype none

module pdu_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_head_valid,
    input  wire pdu_pkg::t_job                 i_head,
    input  wire logic [pdu_pkg::BASE_BITS-1:0] i_year_base,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [4:0]                         o_day,
    output logic [3:0]                         o_month,
    output logic [pdu_pkg::YEAR_BITS-1:0]      o_year,
    output logic                               o_last
);
    import pdu_pkg::*;

    logic                 r_valid;
    logic [1:0]           r_idx;
    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic                 r_last;

    logic  load;
    logic  last;
    t_date cur;

    // Pick the current date of the head job
    always_comb begin
        load  = i_head_valid && (!r_valid || i_ready);
        last  = (r_idx == (i_head.count - 2'd1));
        cur   = i_head.dates[r_idx];
        o_pop = load && last;
    end

    // Hold the output word until taken; step through the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_day   <= cur.day;
            r_month <= cur.month;
            r_year  <= YEAR_BITS'(cur.offset) + YEAR_BITS'(i_year_base);
            r_last  <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_day   = r_day;
    assign o_month = r_month;
    assign o_year  = r_year;
    assign o_last  = r_last;

endmodule

`default_nettype wire
